// File: rtl/core/kq_pkg.sv
package kq_pkg;

  localparam int DEPTH = 16;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  localparam int KeyW   = 20;
  localparam int ScoreW = 9;
  localparam int AmtW   = 16;
  localparam int TotW   = 20;
  localparam int OccW   = 5;

  typedef enum logic [2:0] {
    K_APPEND = 3'd0,
    K_POP    = 3'd1,
    K_PUSH   = 3'd2,
    K_REMOVE = 3'd3,
    K_FILTER = 3'd4,
    K_SUM    = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef struct packed {
    logic [KeyW-1:0]   key;
    logic [ScoreW-1:0] score;
    logic              grant;
    logic [AmtW-1:0]   amount;
  } rec_t;

  typedef struct packed {
    status_e         status;
    rec_t            rec;
    logic [TotW-1:0] total;
    logic [OccW-1:0] removed;
    logic [OccW-1:0] occupancy;
    logic            last;
  } res_t;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    return (p == '0) ? AW'(DEPTH - 1) : p - AW'(1);
  endfunction

endpackage

// File: rtl/core/keyed_queue_with_filter_remove.sv
// Ordered queue of up to DEPTH records (key, Q5.4 score, grant flag, amount) kept in one
// single-port-read, single-port-write RAM as a ring with head and tail pointers. Append,
// push and the unused kinds finish in the accept cycle; pop forms its word from a RAM read in
// the S_POP state. Remove by key, filter removal and the amount sum walk the queue once, one
// RAM read per cycle; remove and filter move each kept record down into the gap. Result words
// appear on the result ports in the cycle after they are formed, each for exactly one cycle
// with result_valid_o high; the receiver cannot stall them. Filter removal gives one word per
// removed record and then a final word with last_o set. busy_o is high while a walk or pop runs.
module keyed_queue_with_filter_remove (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic [2:0]                kind_i,
  input  logic [kq_pkg::KeyW-1:0]   rec_key_i,
  input  logic [kq_pkg::ScoreW-1:0] rec_score_i,
  input  logic                      rec_has_grant_i,
  input  logic [kq_pkg::AmtW-1:0]   rec_amount_i,
  output logic                      result_valid_o,
  output logic [1:0]                status_o,
  output logic [kq_pkg::KeyW-1:0]   out_key_o,
  output logic [kq_pkg::ScoreW-1:0] out_score_o,
  output logic                      out_has_grant_o,
  output logic [kq_pkg::AmtW-1:0]   out_amount_o,
  output logic [kq_pkg::TotW-1:0]   total_amount_o,
  output logic [kq_pkg::OccW-1:0]   removed_count_o,
  output logic [kq_pkg::OccW-1:0]   occupancy_o,
  output logic                      last_o
);
  import kq_pkg::*;

  rec_t          in_rec;
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  rec_t          ram_wdata, ram_rdata;
  logic          res_valid;
  res_t          res;
  logic          res_valid_q;
  res_t          res_q;

  assign in_rec.key    = rec_key_i;
  assign in_rec.score  = rec_score_i;
  assign in_rec.grant  = rec_has_grant_i;
  assign in_rec.amount = rec_amount_i;

  kq_ram #(
    .Width($bits(rec_t)),
    .Depth(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  kq_engine u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .kind_i     (kind_i),
    .in_rec_i   (in_rec),
    .ram_we_o   (ram_we),
    .ram_waddr_o(ram_waddr),
    .ram_wdata_o(ram_wdata),
    .ram_raddr_o(ram_raddr),
    .ram_rdata_i(ram_rdata),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  // result word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      res_q <= res;
    end
  end

  assign result_valid_o  = res_valid_q;
  assign status_o        = res_q.status;
  assign out_key_o       = res_q.rec.key;
  assign out_score_o     = res_q.rec.score;
  assign out_has_grant_o = res_q.rec.grant;
  assign out_amount_o    = res_q.rec.amount;
  assign total_amount_o  = res_q.total;
  assign removed_count_o = res_q.removed;
  assign occupancy_o     = res_q.occupancy;
  assign last_o          = res_q.last;

endmodule

// File: rtl/core/kq_ram.sv
module kq_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: rtl/core/kq_engine.sv
module kq_engine (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [2:0]          kind_i,
  input  kq_pkg::rec_t        in_rec_i,
  output logic                ram_we_o,
  output logic [kq_pkg::AW-1:0] ram_waddr_o,
  output kq_pkg::rec_t        ram_wdata_o,
  output logic [kq_pkg::AW-1:0] ram_raddr_o,
  input  kq_pkg::rec_t        ram_rdata_i,
  output logic                res_valid_o,
  output kq_pkg::res_t        res_o
);
  import kq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_WALK
  } state_e;

  state_e            state_q, state_d;
  logic [AW-1:0]     head_q, head_d, tail_q, tail_d;
  logic [AW-1:0]     rp_q, rp_d, wp_q, wp_d;
  logic [CW-1:0]     count_q, count_d, left_q, left_d, removed_q, removed_d;
  logic              pend_q, pend_d, found_q, found_d;
  logic [TotW-1:0]   total_q, total_d;
  kind_e             kind_q;
  logic [KeyW-1:0]   key_q;
  logic [ScoreW-1:0] thr_q;

  logic              accept;
  logic              drop;
  logic [TotW:0]     sum_ext;

  assign accept = start_i && (state_q == S_IDLE);
  assign busy_o = (state_q != S_IDLE);

  assign sum_ext = {1'b0, total_q} + (TotW + 1)'(ram_rdata_i.amount);

  assign drop = ((kind_q == K_REMOVE) && !found_q && (ram_rdata_i.key == key_q)) ||
                ((kind_q == K_FILTER) && (ram_rdata_i.score < thr_q));

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    tail_d    = tail_q;
    rp_d      = rp_q;
    wp_d      = wp_q;
    count_d   = count_q;
    left_d    = left_q;
    removed_d = removed_q;
    pend_d    = pend_q;
    found_d   = found_q;
    total_d   = total_q;

    ram_we_o    = 1'b0;
    ram_waddr_o = wp_q;
    ram_wdata_o = ram_rdata_i;
    ram_raddr_o = rp_q;

    res_valid_o     = 1'b0;
    res_o           = '0;
    res_o.status    = ST_OK;
    res_o.last      = 1'b1;
    res_o.occupancy = OccW'(count_q);

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          unique case (kind_i)
            K_APPEND: begin
              res_valid_o = 1'b1;
              if (count_q == CW'(DEPTH)) begin
                res_o.status = ST_FULL;
              end else begin
                ram_we_o        = 1'b1;
                ram_waddr_o     = tail_q;
                ram_wdata_o     = in_rec_i;
                tail_d          = ptr_inc(tail_q);
                count_d         = count_q + CW'(1);
                res_o.occupancy = OccW'(count_q + CW'(1));
              end
            end
            K_PUSH: begin
              res_valid_o = 1'b1;
              if (count_q == CW'(DEPTH)) begin
                res_o.status = ST_FULL;
              end else begin
                ram_we_o        = 1'b1;
                ram_waddr_o     = ptr_dec(head_q);
                ram_wdata_o     = in_rec_i;
                head_d          = ptr_dec(head_q);
                count_d         = count_q + CW'(1);
                res_o.occupancy = OccW'(count_q + CW'(1));
              end
            end
            K_POP: begin
              if (count_q == '0) begin
                res_valid_o  = 1'b1;
                res_o.status = ST_EMPTY;
              end else begin
                ram_raddr_o = head_q;
                state_d     = S_POP;
              end
            end
            K_REMOVE, K_FILTER, K_SUM: begin
              if (count_q == '0) begin
                res_valid_o = 1'b1;
                if (kind_i == K_REMOVE) begin
                  res_o.status = ST_EMPTY;
                end
              end else begin
                // start a compaction walk from the head
                ram_raddr_o = head_q;
                rp_d        = ptr_inc(head_q);
                wp_d        = head_q;
                left_d      = count_q - CW'(1);
                pend_d      = 1'b1;
                removed_d   = '0;
                found_d     = 1'b0;
                total_d     = '0;
                state_d     = S_WALK;
              end
            end
            default: begin
              res_valid_o = 1'b1;
            end
          endcase
        end
      end

      S_POP: begin
        res_valid_o     = 1'b1;
        res_o.rec       = ram_rdata_i;
        res_o.occupancy = OccW'(count_q - CW'(1));
        head_d          = ptr_inc(head_q);
        count_d         = count_q - CW'(1);
        state_d         = S_IDLE;
      end

      S_WALK: begin
        if (left_q != '0) begin
          rp_d   = ptr_inc(rp_q);
          left_d = left_q - CW'(1);
          pend_d = 1'b1;
        end else begin
          pend_d = 1'b0;
        end

        if (pend_q) begin
          if (drop) begin
            removed_d       = removed_q + CW'(1);
            found_d         = 1'b1;
            res_valid_o     = 1'b1;
            res_o.rec       = ram_rdata_i;
            res_o.last      = (kind_q == K_REMOVE);
            res_o.occupancy = OccW'(count_q - removed_q - CW'(1));
          end else if (kind_q != K_SUM) begin
            // kept word moves down into the gap
            ram_we_o = 1'b1;
            wp_d     = ptr_inc(wp_q);
          end
          if (kind_q == K_SUM && ram_rdata_i.grant) begin
            total_d = sum_ext[TotW] ? '1 : sum_ext[TotW-1:0];
          end
        end else begin
          state_d = S_IDLE;
          count_d = count_q - removed_q;
          if (kind_q != K_SUM) begin
            tail_d = wp_q;
          end
          unique case (kind_q)
            K_REMOVE: begin
              if (!found_q) begin
                res_valid_o  = 1'b1;
                res_o.status = ST_NOT_FOUND;
              end
            end
            K_FILTER: begin
              res_valid_o     = 1'b1;
              res_o.removed   = OccW'(removed_q);
              res_o.occupancy = OccW'(count_q - removed_q);
            end
            K_SUM: begin
              res_valid_o = 1'b1;
              res_o.total = total_q;
            end
            default: begin
              res_valid_o = 1'b0;
            end
          endcase
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      head_q    <= '0;
      tail_q    <= '0;
      rp_q      <= '0;
      wp_q      <= '0;
      count_q   <= '0;
      left_q    <= '0;
      removed_q <= '0;
      pend_q    <= 1'b0;
      found_q   <= 1'b0;
      total_q   <= '0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      rp_q      <= rp_d;
      wp_q      <= wp_d;
      count_q   <= count_d;
      left_q    <= left_d;
      removed_q <= removed_d;
      pend_q    <= pend_d;
      found_q   <= found_d;
      total_q   <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_e'(kind_i);
      key_q  <= in_rec_i.key;
      thr_q  <= in_rec_i.score;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("count above depth");

  a_removed_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> (removed_q <= count_q))
    else $error("walk removed more than held");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK && ram_we_o && left_q != '0) |-> (ram_waddr_o != ram_raddr_o))
    else $error("walk write hits the entry being read");

  a_append_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && kind_i == K_APPEND && count_q != CW'(DEPTH))
      |=> (count_q == $past(count_q) + CW'(1)))
    else $error("append did not grow the queue");

  a_pop_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POP) |-> (res_valid_o && res_o.last && state_d == S_IDLE))
    else $error("pop gave no word");

endmodule

// File: tb/keyed_queue_with_filter_remove_tb.sv
module keyed_queue_with_filter_remove_tb;
  import kq_pkg::*;

  localparam logic [2:0] K_SPARE6 = 3'd6;
  localparam logic [2:0] K_SPARE7 = 3'd7;
  localparam int RandItems = 300;
  localparam int CycleLimit = 200000;

  class kq_scoreboard;
    rec_t queue_model[$];
    res_t answers[$];
    int errors = 0;
    int n_taken = 0;
    int n_checked = 0;
    int n_full = 0;
    int n_filtered = 0;

    function void post(status_e st, rec_t r, logic [TotW-1:0] tot, logic [OccW-1:0] rem,
                       logic fin);
      res_t w;
      w.status = st;
      w.rec = r;
      w.total = tot;
      w.removed = rem;
      w.occupancy = OccW'(queue_model.size());
      w.last = fin;
      answers.push_back(w);
    endfunction

    // predict the words one accepted command produces
    function void take_command(logic [2:0] k, rec_t r);
      int i;
      int rem;
      int unsigned tot;
      rec_t hit;
      n_taken++;
      case (k)
        K_APPEND, K_PUSH: begin
          if (queue_model.size() >= DEPTH) begin
            n_full++;
            post(ST_FULL, '0, '0, '0, 1'b1);
          end else begin
            if (k == K_APPEND) queue_model.push_back(r);
            else queue_model.push_front(r);
            post(ST_OK, '0, '0, '0, 1'b1);
          end
        end
        K_POP: begin
          if (queue_model.size() == 0) post(ST_EMPTY, '0, '0, '0, 1'b1);
          else begin
            hit = queue_model.pop_front();
            post(ST_OK, hit, '0, '0, 1'b1);
          end
        end
        K_REMOVE: begin
          if (queue_model.size() == 0) post(ST_EMPTY, '0, '0, '0, 1'b1);
          else begin
            i = 0;
            while (i < queue_model.size() && queue_model[i].key != r.key) i++;
            if (i >= queue_model.size()) post(ST_NOT_FOUND, '0, '0, '0, 1'b1);
            else begin
              hit = queue_model[i];
              queue_model.delete(i);
              post(ST_OK, hit, '0, '0, 1'b1);
            end
          end
        end
        K_FILTER: begin
          i = 0;
          rem = 0;
          while (i < queue_model.size()) begin
            if (queue_model[i].score < r.score) begin
              hit = queue_model[i];
              queue_model.delete(i);
              post(ST_OK, hit, '0, '0, 1'b0);
              rem++;
            end else begin
              i++;
            end
          end
          n_filtered += rem;
          post(ST_OK, '0, '0, OccW'(rem), 1'b1);
        end
        K_SUM: begin
          tot = 0;
          foreach (queue_model[j]) begin
            if (queue_model[j].grant) tot += queue_model[j].amount;
            if (tot > 32'hFFFFF) tot = 32'hFFFFF;
          end
          post(ST_OK, '0, TotW'(tot), '0, 1'b1);
        end
        default: post(ST_OK, '0, '0, '0, 1'b1);
      endcase
    endfunction

    function void cmp(string what, logic [31:0] want, logic [31:0] seen);
      if (want !== seen) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, seen);
      end
    endfunction

    function void check_answer(res_t got);
      res_t want;
      if (answers.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word, expected none actual status %0d last %0b",
                 $time, got.status, got.last);
        return;
      end
      want = answers.pop_front();
      n_checked++;
      cmp("status", want.status, got.status);
      cmp("out_key", want.rec.key, got.rec.key);
      cmp("out_score", want.rec.score, got.rec.score);
      cmp("out_has_grant", want.rec.grant, got.rec.grant);
      cmp("out_amount", want.rec.amount, got.rec.amount);
      cmp("total_amount", want.total, got.total);
      cmp("removed_count", want.removed, got.removed);
      cmp("occupancy", want.occupancy, got.occupancy);
      cmp("last", want.last, got.last);
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  logic [2:0]          kind_i;
  logic [KeyW-1:0]     rec_key_i;
  logic [ScoreW-1:0]   rec_score_i;
  logic                rec_has_grant_i;
  logic [AmtW-1:0]     rec_amount_i;
  logic                result_valid_o;
  logic [1:0]          status_o;
  logic [KeyW-1:0]     out_key_o;
  logic [ScoreW-1:0]   out_score_o;
  logic                out_has_grant_o;
  logic [AmtW-1:0]     out_amount_o;
  logic [TotW-1:0]     total_amount_o;
  logic [OccW-1:0]     removed_count_o;
  logic [OccW-1:0]     occupancy_o;
  logic                last_o;

  kq_scoreboard sb = new();
  logic [KeyW-1:0] key_pool[$];
  int cycles = 0;
  res_t got;

  keyed_queue_with_filter_remove uut (
    .clk_i,
    .rst_ni,
    .start_i,
    .busy_o,
    .kind_i,
    .rec_key_i,
    .rec_score_i,
    .rec_has_grant_i,
    .rec_amount_i,
    .result_valid_o,
    .status_o,
    .out_key_o,
    .out_score_o,
    .out_has_grant_o,
    .out_amount_o,
    .total_amount_o,
    .removed_count_o,
    .occupancy_o,
    .last_o
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout, %0d words still expected", $time, sb.answers.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // note the accepted command before checking, so its words queue behind older ones
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o)
        sb.take_command(kind_i, '{rec_key_i, rec_score_i, rec_has_grant_i, rec_amount_i});
      if (result_valid_o) begin
        got.status = status_e'(status_o);
        got.rec = '{out_key_o, out_score_o, out_has_grant_o, out_amount_o};
        got.total = total_amount_o;
        got.removed = removed_count_o;
        got.occupancy = occupancy_o;
        got.last = last_o;
        sb.check_answer(got);
      end
    end
  end

  // hold the command word until the block takes it
  task automatic send_word(input logic [2:0] k, input logic [KeyW-1:0] key,
                           input logic [ScoreW-1:0] score, input logic grant,
                           input logic [AmtW-1:0] amt);
    start_i <= 1'b1;
    kind_i <= k;
    rec_key_i <= key;
    rec_score_i <= score;
    rec_has_grant_i <= grant;
    rec_amount_i <= amt;
    if (k == K_APPEND || k == K_PUSH) begin
      key_pool.push_back(key);
      if (key_pool.size() > 16) void'(key_pool.pop_front());
    end
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic pause(input int n);
    start_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  function automatic logic [KeyW-1:0] pick_key(input bit from_pool);
    if (from_pool && key_pool.size() != 0)
      return key_pool[$urandom_range(0, key_pool.size() - 1)];
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3, 4, 5: return KeyW'($urandom_range(0, 7));
      default: return KeyW'($urandom);
    endcase
  endfunction

  function automatic logic [ScoreW-1:0] pick_score();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return ScoreW'($urandom);
    endcase
  endfunction

  function automatic logic [AmtW-1:0] pick_amount();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return AmtW'($urandom);
    endcase
  endfunction

  function automatic logic [2:0] pick_kind(input int mode);
    int r;
    r = $urandom_range(0, 19);
    case (mode)
      0: begin
        if (r < 11) return K_APPEND;
        if (r < 16) return K_PUSH;
        if (r < 18) return K_SUM;
        return K_POP;
      end
      1: begin
        if (r < 6) return K_POP;
        if (r < 12) return K_REMOVE;
        if (r < 16) return K_FILTER;
        if (r < 18) return K_SUM;
        return K_APPEND;
      end
      default: begin
        if (r == 19) return ($urandom_range(0, 1) != 0) ? K_SPARE6 : K_SPARE7;
        return 3'($urandom_range(0, 5));
      end
    endcase
  endfunction

  initial begin
    int sent;
    int mode;
    int phase_left;
    int burst_left;
    bit quiet;
    logic [2:0] k;
    start_i = 1'b0;
    kind_i = '0;
    rec_key_i = '0;
    rec_score_i = '0;
    rec_has_grant_i = 1'b0;
    rec_amount_i = '0;
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // empty queue on every operation that reads it, then unused kinds
    send_word(K_POP, '0, '0, 1'b0, '0);
    send_word(K_REMOVE, 20'h12345, '0, 1'b0, '0);
    send_word(K_FILTER, '0, '1, 1'b0, '0);
    send_word(K_SUM, '0, '0, 1'b0, '0);
    send_word(K_SPARE6, '1, '1, 1'b1, '1);
    send_word(K_SPARE7, '0, '0, 1'b0, '0);
    // field extremes, duplicate key nearest the head, absent key
    send_word(K_APPEND, '0, '0, 1'b0, '0);
    send_word(K_APPEND, '1, '1, 1'b1, '1);
    send_word(K_PUSH, 20'h00005, 9'h080, 1'b1, 16'h1234);
    send_word(K_APPEND, 20'h00005, 9'h010, 1'b1, 16'h0001);
    send_word(K_APPEND, 20'h00ABC, '1, 1'b1, '1);
    send_word(K_SUM, '0, '0, 1'b0, '0);
    send_word(K_REMOVE, 20'h00005, '0, 1'b0, '0);
    send_word(K_REMOVE, 20'h54321, '0, 1'b0, '0);
    send_word(K_FILTER, '0, '0, 1'b0, '0);
    send_word(K_FILTER, '0, 9'h100, 1'b0, '0);
    send_word(K_POP, '0, '0, 1'b0, '0);
    send_word(K_SUM, '0, '0, 1'b0, '0);
    send_word(K_FILTER, '0, '1, 1'b0, '0);
    pause($urandom_range(1, 4));

    // phases biased toward filling, draining or a mix; bursts with random gaps
    sent = 0;
    phase_left = 0;
    burst_left = $urandom_range(1, 8);
    mode = 0;
    quiet = 1'b0;
    while (sent < RandItems) begin
      if (phase_left == 0) begin
        mode = (sent == 0) ? 0 : $urandom_range(0, 2);
        phase_left = (mode == 0) ? $urandom_range(18, 30) : $urandom_range(8, 24);
        quiet = ($urandom_range(0, 3) == 0);
      end
      k = pick_kind(mode);
      case (k)
        K_REMOVE:
          send_word(k, pick_key($urandom_range(0, 3) != 0), pick_score(),
                    1'($urandom), pick_amount());
        default:
          send_word(k, pick_key(1'b0), pick_score(), 1'($urandom), pick_amount());
      endcase
      sent++;
      phase_left--;
      burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 8);
        if (!quiet) pause($urandom_range(1, 10));
      end
    end

    start_i <= 1'b0;
    while (sb.answers.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("Ran %0d commands, checked %0d result words.", sb.n_taken, sb.n_checked);
    $display("Full-queue rejects: %0d, records removed by filter: %0d.",
             sb.n_full, sb.n_filtered);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
